// ----- hw/rtl/crs_pkg.sv -----
// Shared types, constants and the weight function of the spline segment sampler.
// No dependencies; imported by crs_blend and catmull_rom_segment_sampler_top.
`timescale 1ns / 1ps

package crs_pkg;

    localparam int SAMPLES_PER_SEGMENT = 11;
    localparam int COORD_BITS          = 12;

    // Segment divisions and sample counter width.
    localparam int N_SEG  = SAMPLES_PER_SEGMENT - 1;
    localparam int K_BITS = $clog2(SAMPLES_PER_SEGMENT);

    // Field widths fixed by the stream format.
    localparam int IN_BITS    = 12;
    localparam int OUT_BITS   = 14;
    localparam int INDEX_BITS = 4;
    localparam int OUT_MAX    = (1 << (OUT_BITS - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_BITS - 1));

    // Coordinates carry one extra bit so the flipped y can go negative.
    localparam int PB = COORD_BITS + 1;

    // Weight scale 2*n^3 and rounding divisor 4*n^3.
    localparam longint DEN = 64'sd2 * N_SEG * N_SEG * N_SEG;
    localparam longint DIV = 64'sd2 * DEN;
    localparam int     WB  = $clog2(DEN + 1) + 1;

    // Accumulator width and the bias that makes it non-negative before division.
    localparam int     NUM_BITS = PB + WB + 3;
    localparam int     U_BITS   = NUM_BITS + 1;
    localparam longint BIAS_Q   = ((64'sd1 <<< (NUM_BITS - 1)) + DIV - 1) / DIV;
    localparam longint OFFSET   = BIAS_Q * DIV;

    // Reciprocal of the divisor; the estimate is low by at most one.
    localparam int     R_SHIFT = U_BITS;
    localparam longint RECIP   = (64'sd1 <<< R_SHIFT) / DIV;
    localparam int     R_BITS  = $clog2(RECIP + 1);

    typedef logic signed [PB-1:0] coord_t;
    typedef logic signed [WB-1:0] weight_t;

    typedef struct packed {
        logic              valid;
        logic [K_BITS-1:0] idx;
        logic              last;
    } crs_tag_t;

    // Uniform spline basis weight j for sample kk, scaled by 2*n^3.
    function automatic weight_t cr_weight(input int j, input int kk);
        longint n;
        longint k;
        longint w;
        n = N_SEG;
        k = kk;
        case (j)
            0:       w = -k * n * n + 2 * k * k * n - k * k * k;
            1:       w = 2 * n * n * n - 5 * k * k * n + 3 * k * k * k;
            2:       w = k * n * n + 4 * k * k * n - 3 * k * k * k;
            default: w = -k * k * n + k * k * k;
        endcase
        return WB'(w);
    endfunction

endpackage

// ----- hw/rtl/catmull_rom_segment_sampler_top.sv -----
// Top level of the uniform spline segment sampler: point history, sample sequencer, streams.
// Depends on crs_pkg and crs_blend.
`timescale 1ns / 1ps

// Channel   Direction  Bits of tdata / tuser / tlast
// s_axis    in         tdata[11:0] x_in, tdata[23:12] y_raw; tuser restart
// m_axis    out        tdata[13:0] x_out, [27:14] y_out, [31:28] sample_index; tlast last
// cfg       in         cfg_wdata window_height, written when cfg_we is high
//
// A point that closes a four-point window starts the sample sequencer, which issues
// one sample per advancing cycle into a five-stage blend pipeline; a stall on m_axis
// holds it. A warm-up or restart point gives no transaction.
// A stall on m_axis freezes the whole pipeline; reset clears the point
// history, the sequencer and all pipeline valid bits, and sets window_height to 400.

module catmull_rom_segment_sampler_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // x_in[11:0], y_raw[23:12]
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // x_out[13:0], y_out[27:14], sample_index[31:28]
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata       // window_height
);
    import crs_pkg::*;

    localparam int STAGES = 5;
    localparam logic [K_BITS-1:0] K_LAST = K_BITS'(N_SEG);

    logic [11:0]       height_reg;
    coord_t            hist_x_reg [3];
    coord_t            hist_y_reg [3];
    logic [1:0]        held_reg;
    coord_t            win_x_reg [4];
    coord_t            win_y_reg [4];
    logic              busy_reg;
    logic [K_BITS-1:0] k_reg;
    crs_tag_t          tag_reg [STAGES];

    logic              advance;
    logic              accept;
    logic [1:0]        held_eff;
    logic              closes;
    coord_t            px, py;
    weight_t           weights [4];
    logic [OUT_BITS-1:0] x_res, y_res;

    assign advance       = !tag_reg[STAGES-1].valid || m_axis_tready;
    assign s_axis_tready = !busy_reg || (advance && (k_reg == K_LAST));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign px       = PB'(COORD_BITS'(s_axis_tdata[IN_BITS-1:0]));
    assign py       = PB'(height_reg) - PB'(s_axis_tdata[2*IN_BITS-1:IN_BITS]);
    assign held_eff = s_axis_tuser ? 2'd0 : held_reg;
    assign closes   = (held_eff == 2'd3);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            weights[j] = '0;
            for (int kk = 0; kk <= N_SEG; kk++)
            begin
                if (K_BITS'(kk) == k_reg)
                begin
                    weights[j] = cr_weight(j, kk);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 12'd400;
        end
        else if (cfg_we)
        begin
            height_reg <= cfg_wdata;
        end
    end

    // History update and window capture on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (closes)
            begin
                held_reg <= 2'd3;
            end
            else
            begin
                held_reg <= held_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (closes)
            begin
                win_x_reg[0]  <= hist_x_reg[0];
                win_x_reg[1]  <= hist_x_reg[1];
                win_x_reg[2]  <= hist_x_reg[2];
                win_x_reg[3]  <= px;
                win_y_reg[0]  <= hist_y_reg[0];
                win_y_reg[1]  <= hist_y_reg[1];
                win_y_reg[2]  <= hist_y_reg[2];
                win_y_reg[3]  <= py;
                hist_x_reg[0] <= hist_x_reg[1];
                hist_x_reg[1] <= hist_x_reg[2];
                hist_x_reg[2] <= px;
                hist_y_reg[0] <= hist_y_reg[1];
                hist_y_reg[1] <= hist_y_reg[2];
                hist_y_reg[2] <= py;
            end
            else
            begin
                hist_x_reg[held_eff] <= px;
                hist_y_reg[held_eff] <= py;
            end
        end
    end

    // Sample sequencer: one sample per advancing cycle while a window is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            if (busy_reg && advance)
            begin
                if (k_reg == K_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                k_reg <= k_reg + K_BITS'(1);
            end
            if (accept && closes)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            tag_reg[0] <= '{valid: busy_reg, idx: k_reg, last: (k_reg == K_LAST)};
            for (int i = 1; i < STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    crs_blend u_blend_x
    (
        .clk     (clk),
        .en      (advance),
        .pts     (win_x_reg),
        .weights (weights),
        .result  (x_res)
    );

    crs_blend u_blend_y
    (
        .clk     (clk),
        .en      (advance),
        .pts     (win_y_reg),
        .weights (weights),
        .result  (y_res)
    );

    assign m_axis_tvalid = tag_reg[STAGES-1].valid;
    assign m_axis_tlast  = tag_reg[STAGES-1].last;
    assign m_axis_tdata  = {INDEX_BITS'(tag_reg[STAGES-1].idx), y_res, x_res};

endmodule

// ----- hw/rtl/crs_blend.sv -----
// Five-stage blend datapath for one coordinate: weighted sum, rounding division, saturation.
// Depends on crs_pkg for widths, scale constants and types.
`timescale 1ns / 1ps

module crs_blend
(
    input  logic                      clk,
    input  logic                      en,
    input  crs_pkg::coord_t           pts [4],
    input  crs_pkg::weight_t          weights [4],
    output logic [crs_pkg::OUT_BITS-1:0] result
);
    import crs_pkg::*;

    localparam int PRB = PB + WB;

    localparam logic [U_BITS-1:0]       DIV_U    = U_BITS'(DIV);
    localparam logic [U_BITS-1:0]       OFFSET_U = U_BITS'(OFFSET);
    localparam logic [R_BITS-1:0]       RECIP_V  = R_BITS'(RECIP);
    localparam logic signed [NUM_BITS-1:0] DEN_S = NUM_BITS'(DEN);
    localparam logic signed [U_BITS:0]  Q_BIAS   = (U_BITS + 1)'(BIAS_Q);
    localparam logic signed [U_BITS:0]  Q_HI     = (U_BITS + 1)'(OUT_MAX);
    localparam logic signed [U_BITS:0]  Q_LO     = (U_BITS + 1)'(OUT_MIN);

    logic signed [PRB-1:0]      prod_reg [4];
    logic signed [PRB-1:0]      prod_next [4];
    logic [U_BITS-1:0]          u_reg, u_next;
    logic [U_BITS-1:0]          u3_reg;
    logic [U_BITS-1:0]          est_reg, est_next;
    logic signed [U_BITS:0]     q_reg, q_next;
    logic [OUT_BITS-1:0]        out_reg, out_next;

    logic signed [NUM_BITS-1:0] sum_s;
    logic signed [NUM_BITS-1:0] num2;
    logic [U_BITS+R_BITS-1:0]   prod_r;
    logic [U_BITS-1:0]          rem;
    logic [U_BITS-1:0]          est_c;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod_next[j] = PRB'(weights[j]) * PRB'(pts[j]);
        end
    end

    // Rounded to nearest: floor((2*sum + den) / (2*den)), biased to stay non-negative.
    always_comb
    begin
        sum_s  = NUM_BITS'(prod_reg[0]) + NUM_BITS'(prod_reg[1])
               + NUM_BITS'(prod_reg[2]) + NUM_BITS'(prod_reg[3]);
        num2   = (sum_s <<< 1) + DEN_S;
        u_next = U_BITS'(num2) + OFFSET_U;
    end

    always_comb
    begin
        prod_r   = u_reg * RECIP_V;
        est_next = U_BITS'(prod_r >> R_SHIFT);
    end

    // The reciprocal estimate may be one short; the remainder check fixes it.
    always_comb
    begin
        rem    = u3_reg - est_reg * DIV_U;
        est_c  = est_reg + U_BITS'(rem >= DIV_U);
        q_next = $signed({1'b0, est_c}) - Q_BIAS;
    end

    always_comb
    begin
        if (q_reg > Q_HI)
        begin
            out_next = OUT_BITS'(Q_HI);
        end
        else if (q_reg < Q_LO)
        begin
            out_next = OUT_BITS'(Q_LO);
        end
        else
        begin
            out_next = OUT_BITS'(q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
            u_reg   <= u_next;
            u3_reg  <= u_reg;
            est_reg <= est_next;
            q_reg   <= q_next;
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule
